FILE: design/nbd_pkg.sv
package nbd_pkg;

   localparam int BYTE_W     = 8;
   localparam int DIM_W      = 13;
   localparam int SCALE_W    = 5;
   localparam int DIVR_W     = 2 * SCALE_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = DIM_W;

   localparam int DEF_MAX_WIDTH = 4096;
   localparam int DEF_MAX_SCALE = 16;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_FACTOR = 2'd2;

   localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH  = 13'd640;
   localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT = 13'd480;
   localparam logic [SCALE_W-1:0] RST_SCALE_FACTOR = 5'd2;

   // block sum width, reciprocal shift and reciprocal width
   function automatic int sum_width(int max_scale);
      return BYTE_W + 2 * $clog2(max_scale);
   endfunction

   function automatic int shift_width(int max_scale);
      return sum_width(max_scale) + DIVR_W;
   endfunction

   function automatic int recip_width(int max_scale);
      return shift_width(max_scale) - 1;
   endfunction

   typedef struct packed {
      logic               usable;
      logic [DIM_W-1:0]   width_last;
      logic [DIM_W-1:0]   luma_rows_last;
      logic [DIM_W-1:0]   chroma_rows_last;
      logic [DIM_W-1:0]   luma_blocks;
      logic [DIM_W-1:0]   chroma_pairs;
      logic [DIM_W-1:0]   luma_bands;
      logic [DIM_W-1:0]   chroma_bands;
      logic [SCALE_W-1:0] scale_last;
   } geom_type;

   typedef struct packed {
      logic valid;
      logic is_chroma;
      logic last;
   } tag_type;

endpackage

FILE: design/nbd_div.sv
module nbd_div
   import nbd_pkg::*;
#(
   parameter int NUM_W = shift_width(DEF_MAX_SCALE) + 1,
   parameter int DEN_W = DIVR_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] num_ff;
   logic [NUM_W-1:0] num_in;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;
   logic             step_last;

   // one quotient bit per cycle, msb first
   assign trial     = {rem_ff, num_ff[NUM_W-1]};
   assign diff      = trial - {1'b0, den_ff};
   assign ge        = trial >= {1'b0, den_ff};
   assign rem_in    = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
   assign num_in    = {num_ff[NUM_W-2:0], ge};
   assign step_last = busy_ff && (cnt_ff == CNT_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else begin
         done_ff <= step_last;
         if (step_last) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule

FILE: design/nbd_setup.sv
module nbd_setup
   import nbd_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_SCALE = DEF_MAX_SCALE
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic [CSR_IDX_W-1:0]              csr_index,
   input  logic [CSR_DATA_W-1:0]             csr_wdata,
   output logic                              csr_ready,
   output logic                              restart,
   output logic                              ready,
   output geom_type                          geom,
   output logic [recip_width(MAX_SCALE)-1:0] recip
);

   localparam int SHIFT_K = shift_width(MAX_SCALE);
   localparam int NUM_W   = SHIFT_K + 1;
   localparam int REC_W   = recip_width(MAX_SCALE);

   localparam logic [NUM_W-1:0] ONE_K  = {1'b1, {SHIFT_K{1'b0}}};
   localparam logic [DIM_W:0]   MAXW_X = (DIM_W + 1)'(MAX_WIDTH);

   localparam logic [1:0] ST_WDIV = 2'd0;
   localparam logic [1:0] ST_HDIV = 2'd1;
   localparam logic [1:0] ST_RDIV = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]         state_ff;
   logic               go_ff;
   logic [DIM_W-1:0]   width_ff;
   logic [DIM_W-1:0]   width_in;
   logic [DIM_W-1:0]   height_ff;
   logic [DIM_W-1:0]   height_in;
   logic [SCALE_W-1:0] scale_ff;
   logic [SCALE_W-1:0] scale_in;
   logic               csr_hit;
   logic [DIVR_W-1:0]  sq_ff;
   logic [DIM_W-1:0]   wq_ff;
   logic [DIM_W-1:0]   hq_ff;
   logic [REC_W-1:0]   recip_ff;
   logic [DIM_W-1:0]   w_eff;
   logic [NUM_W-1:0]   div_num;
   logic [DIVR_W-1:0]  div_den;
   logic               div_done;
   logic [NUM_W-1:0]   div_quot;
   logic               div_take;
   logic               scale_ok;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      scale_in  = scale_ff;
      csr_hit   = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            REG_FRAME_WIDTH: begin
               width_in = csr_wdata;
               csr_hit  = 1'b1;
            end
            REG_FRAME_HEIGHT: begin
               height_in = csr_wdata;
               csr_hit   = 1'b1;
            end
            REG_SCALE_FACTOR: begin
               scale_in = csr_wdata[SCALE_W-1:0];
               csr_hit  = 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign restart  = csr_hit;
   assign div_take = div_done && !go_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_WDIV;
         go_ff     <= 1'b1;
         width_ff  <= RST_FRAME_WIDTH;
         height_ff <= RST_FRAME_HEIGHT;
         scale_ff  <= RST_SCALE_FACTOR;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         scale_ff  <= scale_in;
         go_ff     <= 1'b0;
         if (csr_hit) begin
            state_ff <= ST_WDIV;
            go_ff    <= 1'b1;
         end else if (div_take) begin
            unique case (state_ff)
               ST_WDIV: begin
                  state_ff <= ST_HDIV;
                  go_ff    <= 1'b1;
               end
               ST_HDIV: begin
                  state_ff <= ST_RDIV;
                  go_ff    <= 1'b1;
               end
               ST_RDIV: state_ff <= ST_DONE;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      sq_ff <= scale_ff * scale_ff;
      if (div_take) begin
         unique case (state_ff)
            ST_WDIV: wq_ff    <= div_quot[DIM_W-1:0];
            ST_HDIV: hq_ff    <= div_quot[DIM_W-1:0];
            ST_RDIV: recip_ff <= div_quot[REC_W-1:0];
            default: ;
         endcase
      end
   end

   assign w_eff = ({1'b0, width_ff} > MAXW_X) ? MAXW_X[DIM_W-1:0] : width_ff;

   always_comb begin
      unique case (state_ff)
         ST_WDIV: begin
            div_num = NUM_W'(w_eff);
            div_den = DIVR_W'(scale_ff);
         end
         ST_HDIV: begin
            div_num = NUM_W'(height_ff);
            div_den = DIVR_W'(scale_ff);
         end
         ST_RDIV: begin
            // ceiling reciprocal of scale squared
            div_num = ONE_K + NUM_W'(sq_ff) - NUM_W'(1);
            div_den = sq_ff;
         end
         default: begin
            div_num = '0;
            div_den = '0;
         end
      endcase
   end

   nbd_div #(
      .NUM_W (NUM_W),
      .DEN_W (DIVR_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (go_ff),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign scale_ok = (scale_ff >= SCALE_W'(2)) && (32'(scale_ff) <= 32'(MAX_SCALE));

   always_comb begin
      geom.usable           = scale_ok && (wq_ff >= DIM_W'(2)) && (hq_ff >= DIM_W'(2));
      geom.width_last       = w_eff - DIM_W'(1);
      geom.luma_rows_last   = height_ff - DIM_W'(1);
      geom.chroma_rows_last = {1'b0, height_ff[DIM_W-1:1]} - DIM_W'(1);
      geom.luma_blocks      = wq_ff;
      geom.chroma_pairs     = {1'b0, wq_ff[DIM_W-1:1]};
      geom.luma_bands       = hq_ff;
      geom.chroma_bands     = {1'b0, hq_ff[DIM_W-1:1]};
      geom.scale_last       = scale_ff - SCALE_W'(1);
   end

   assign ready = (state_ff == ST_DONE);
   assign recip = recip_ff;

endmodule

FILE: design/nbd_accum.sv
module nbd_accum
   import nbd_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_SCALE = DEF_MAX_SCALE
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            restart,
   input  logic                            accept,
   input  logic                            advance,
   input  logic [BYTE_W-1:0]               source_byte,
   input  geom_type                        geom,
   output logic [sum_width(MAX_SCALE)-1:0] block_sum,
   output tag_type                         tag
);

   localparam int SUM_W     = sum_width(MAX_SCALE);
   localparam int ACC_DEPTH = MAX_WIDTH / 2;
   localparam int A_W       = $clog2(ACC_DEPTH);
   localparam int COL_W     = $clog2(MAX_WIDTH);

   logic [SUM_W-1:0]   sums_ff [ACC_DEPTH];
   logic [SUM_W-1:0]   rdata_ff;

   logic [COL_W-1:0]   col_ff;
   logic [COL_W-1:0]   col_in;
   logic [COL_W-1:0]   blk_ff;
   logic [COL_W-1:0]   blk_in;
   logic [SCALE_W-1:0] pos_ff;
   logic [SCALE_W-1:0] pos_in;
   logic               comp_ff;
   logic               comp_in;
   logic [DIM_W-1:0]   row_ff;
   logic [DIM_W-1:0]   row_in;
   logic [SCALE_W-1:0] rib_ff;
   logic [SCALE_W-1:0] rib_in;
   logic [DIM_W-1:0]   band_ff;
   logic [DIM_W-1:0]   band_in;
   logic               chroma_ff;
   logic               chroma_in;

   logic [DIM_W-1:0]   blk_wide;
   logic               col_end;
   logic               row_end;
   logic               pos_last;
   logic               rib_last;
   logic               in_range;
   logic               first;
   logic               emit;
   logic               last_flag;
   logic               rd_en;
   logic [A_W-1:0]     addr;

   logic               s1_valid_ff;
   logic [A_W-1:0]     s1_addr_ff;
   logic [BYTE_W-1:0]  s1_byte_ff;
   logic               s1_first_ff;
   logic               s1_emit_ff;
   logic               s1_chroma_ff;
   logic               s1_last_ff;
   logic               s1_fwd_ff;
   logic [SUM_W-1:0]   s1_fwd_data_ff;
   logic [SUM_W-1:0]   s1_base;
   logic [SUM_W-1:0]   s1_sum;

   logic               s2_valid_ff;
   logic [SUM_W-1:0]   s2_sum_ff;
   logic               s2_chroma_ff;
   logic               s2_last_ff;

   assign blk_wide = DIM_W'(blk_ff);
   assign col_end  = DIM_W'(col_ff) == geom.width_last;
   assign row_end  = chroma_ff ? (row_ff == geom.chroma_rows_last)
                               : (row_ff == geom.luma_rows_last);
   assign pos_last = pos_ff == geom.scale_last;
   assign rib_last = rib_ff == geom.scale_last;

   assign in_range = chroma_ff
      ? ((band_ff < geom.chroma_bands) && (blk_wide < geom.chroma_pairs))
      : ((band_ff < geom.luma_bands) && (blk_wide < geom.luma_blocks));
   assign first     = (rib_ff == '0) && (pos_ff == '0);
   assign emit      = rib_last && pos_last;
   assign last_flag = chroma_ff && comp_ff
                      && (blk_wide == geom.chroma_pairs - DIM_W'(1))
                      && (band_ff == geom.chroma_bands - DIM_W'(1));
   // chroma keeps u and v of a block pair in adjacent entries
   assign addr  = chroma_ff ? {blk_ff[A_W-2:0], comp_ff} : blk_ff[A_W-1:0];
   assign rd_en = accept && geom.usable && in_range;

   always_comb begin
      col_in    = col_ff;
      blk_in    = blk_ff;
      pos_in    = pos_ff;
      comp_in   = comp_ff;
      row_in    = row_ff;
      rib_in    = rib_ff;
      band_in   = band_ff;
      chroma_in = chroma_ff;
      if (restart) begin
         col_in    = '0;
         blk_in    = '0;
         pos_in    = '0;
         comp_in   = 1'b0;
         row_in    = '0;
         rib_in    = '0;
         band_in   = '0;
         chroma_in = 1'b0;
      end else if (accept && geom.usable) begin
         if (col_end) begin
            col_in  = '0;
            blk_in  = '0;
            pos_in  = '0;
            comp_in = 1'b0;
            if (row_end) begin
               row_in    = '0;
               rib_in    = '0;
               band_in   = '0;
               chroma_in = !chroma_ff;
            end else begin
               row_in = row_ff + DIM_W'(1);
               if (rib_last) begin
                  rib_in  = '0;
                  band_in = band_ff + DIM_W'(1);
               end else begin
                  rib_in = rib_ff + SCALE_W'(1);
               end
            end
         end else begin
            col_in  = col_ff + COL_W'(1);
            comp_in = chroma_ff && !comp_ff;
            if (!chroma_ff || comp_ff) begin
               if (pos_last) begin
                  pos_in = '0;
                  blk_in = blk_ff + COL_W'(1);
               end else begin
                  pos_in = pos_ff + SCALE_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         blk_ff    <= '0;
         pos_ff    <= '0;
         comp_ff   <= 1'b0;
         row_ff    <= '0;
         rib_ff    <= '0;
         band_ff   <= '0;
         chroma_ff <= 1'b0;
      end else begin
         col_ff    <= col_in;
         blk_ff    <= blk_in;
         pos_ff    <= pos_in;
         comp_ff   <= comp_in;
         row_ff    <= row_in;
         rib_ff    <= rib_in;
         band_ff   <= band_in;
         chroma_ff <= chroma_in;
      end
   end

   // read data is registered, so a write to the same entry in the read cycle is forwarded
   assign s1_base = s1_fwd_ff ? s1_fwd_data_ff : rdata_ff;
   assign s1_sum  = s1_first_ff ? SUM_W'(s1_byte_ff) : s1_base + SUM_W'(s1_byte_ff);

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= sums_ff[addr];
      end
      if (s1_valid_ff && advance) begin
         sums_ff[s1_addr_ff] <= s1_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= rd_en;
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_addr_ff     <= addr;
         s1_byte_ff     <= source_byte;
         s1_first_ff    <= first;
         s1_emit_ff     <= emit;
         s1_chroma_ff   <= chroma_ff;
         s1_last_ff     <= last_flag;
         s1_fwd_ff      <= s1_valid_ff && (s1_addr_ff == addr);
         s1_fwd_data_ff <= s1_sum;
         s2_sum_ff      <= s1_sum;
         s2_chroma_ff   <= s1_chroma_ff;
         s2_last_ff     <= s1_last_ff;
      end
   end

   assign block_sum     = s2_sum_ff;
   assign tag.valid     = s2_valid_ff;
   assign tag.is_chroma = s2_chroma_ff;
   assign tag.last      = s2_last_ff;

endmodule

FILE: design/nbd_out.sv
module nbd_out
   import nbd_pkg::*;
#(
   parameter int MAX_SCALE = DEF_MAX_SCALE
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [sum_width(MAX_SCALE)-1:0]   block_sum,
   input  tag_type                           tag,
   input  logic [recip_width(MAX_SCALE)-1:0] recip,
   output logic                              advance,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [BYTE_W-1:0]                 rsp_scaled_byte,
   output logic                              rsp_is_chroma,
   output logic                              rsp_last_of_frame
);

   localparam int SUM_W   = sum_width(MAX_SCALE);
   localparam int REC_W   = recip_width(MAX_SCALE);
   localparam int SHIFT_K = shift_width(MAX_SCALE);
   localparam int PROD_W  = SUM_W + REC_W;

   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] s3_prod_ff;
   tag_type           s3_tag_ff;
   logic              out_valid_ff;
   logic [BYTE_W-1:0] out_byte_ff;
   logic              out_chroma_ff;
   logic              out_last_ff;

   assign advance = !out_valid_ff || !rsp_stall;
   // floor division by scale squared through the ceiling reciprocal
   assign prod    = block_sum * recip;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_tag_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_tag_ff    <= tag;
         out_valid_ff <= s3_tag_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_prod_ff    <= prod;
         out_byte_ff   <= s3_prod_ff[SHIFT_K +: BYTE_W];
         out_chroma_ff <= s3_tag_ff.is_chroma;
         out_last_ff   <= s3_tag_ff.last;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_scaled_byte   = out_byte_ff;
   assign rsp_is_chroma     = out_chroma_ff;
   assign rsp_last_of_frame = out_last_ff;

endmodule

FILE: design/nv12_box_downscale.sv
// box downscaler for semi-planar 4:2:0 frames
// req channel: one frame byte per item, luma plane rows first, then the
// interleaved u/v rows. an item is taken when req_valid is high and
// req_stall is low. rsp channel: one averaged byte per finished block, in
// output raster order, with is_chroma and last_of_frame tags.
// csr channel: frame_width (0), frame_height (1), scale_factor (2); a write
// to one of them restarts the frame at its first byte. csr_ready is always high.
// throughput: one item per cycle while req_stall is low. a result for a
// block goes through the s1, s2, s3 and output registers after the item that
// closes it; the accumulator line is a one-read one-write ram, read when the
// item is taken and written back as it leaves s1. after reset and after each
// register write, a shared bit-serial divider derives the block counts and
// the scale-squared reciprocal; req_stall stays high until it is done.
// reset restores 640x480 at scale 2 and starts at the frame's first byte.
// while rsp_stall holds a waiting result, the whole pipe freezes and
// req_stall is raised; nothing is dropped.
// unusable settings (scale below 2 or above MAX_SCALE, fewer than two
// blocks across or down) take items and give no result.
module nv12_box_downscale
   import nbd_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_SCALE = DEF_MAX_SCALE
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [BYTE_W-1:0]     req_source_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [BYTE_W-1:0]     rsp_scaled_byte,
   output logic                  rsp_is_chroma,
   output logic                  rsp_last_of_frame,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SUM_W = sum_width(MAX_SCALE);
   localparam int REC_W = recip_width(MAX_SCALE);

   logic             restart;
   logic             setup_ready;
   geom_type         geom;
   logic [REC_W-1:0] recip;
   logic             advance;
   logic             accept;
   logic [SUM_W-1:0] block_sum;
   tag_type          tag;

   assign req_stall = !setup_ready || !advance;
   assign accept    = req_valid && !req_stall;

   nbd_setup #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_SCALE (MAX_SCALE)
   ) u_setup (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr_ready (csr_ready),
      .restart   (restart),
      .ready     (setup_ready),
      .geom      (geom),
      .recip     (recip)
   );

   nbd_accum #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_SCALE (MAX_SCALE)
   ) u_accum (
      .clock       (clock),
      .reset       (reset),
      .restart     (restart),
      .accept      (accept),
      .advance     (advance),
      .source_byte (req_source_byte),
      .geom        (geom),
      .block_sum   (block_sum),
      .tag         (tag)
   );

   nbd_out #(
      .MAX_SCALE (MAX_SCALE)
   ) u_out (
      .clock             (clock),
      .reset             (reset),
      .block_sum         (block_sum),
      .tag               (tag),
      .recip             (recip),
      .advance           (advance),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_scaled_byte   (rsp_scaled_byte),
      .rsp_is_chroma     (rsp_is_chroma),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule
